### rtl/core/mch_pkg.sv
package mch_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int DIV_BITS = 34;

	localparam logic [2:0] REG_X_MIN = 3'd0;
	localparam logic [2:0] REG_X_MAX = 3'd1;
	localparam logic [2:0] REG_Y_MIN = 3'd2;
	localparam logic [2:0] REG_Y_MAX = 3'd3;
	localparam logic [2:0] REG_Z_MIN = 3'd4;
	localparam logic [2:0] REG_Z_MAX = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO_SAMPLE = 2'd1;
	localparam logic [1:0] ST_ZERO_SPAN = 2'd2;

	typedef struct packed {
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
	} sample_t;

	typedef struct packed {
		logic [8:0] heading_deg;
		logic [1:0] status;
	} result_t;

	// Arctangent of 2^-i in units of 2^-16 degree, rounded to nearest.
	function automatic logic [21:0] atan_lut(input int i);
		logic [21:0] v;
		begin
			case (i)
				0: v = 22'd2949120;
				1: v = 22'd1740967;
				2: v = 22'd919879;
				3: v = 22'd466945;
				4: v = 22'd234379;
				5: v = 22'd117304;
				6: v = 22'd58666;
				7: v = 22'd29335;
				8: v = 22'd14668;
				9: v = 22'd7334;
				10: v = 22'd3667;
				11: v = 22'd1833;
				12: v = 22'd917;
				13: v = 22'd458;
				14: v = 22'd229;
				15: v = 22'd115;
				16: v = 22'd57;
				17: v = 22'd29;
				18: v = 22'd14;
				19: v = 22'd7;
				20: v = 22'd4;
				21: v = 22'd2;
				22: v = 22'd1;
				default: v = 22'd0;
			endcase
			return v;
		end
	endfunction

	// Halves a 17-bit signed value, truncating toward zero.
	function automatic logic signed [16:0] half_tz(input logic signed [16:0] a);
		logic signed [16:0] t;
		begin
			t = a + {16'd0, a[16]};
			return t >>> 1;
		end
	endfunction

endpackage

### rtl/core/magnetometer_calibrated_heading_core.sv
// Calibrated compass heading. One sample is taken on every cycle that start is high
// (busy stays low), and its result is strobed by done as it leaves the output register;
// the receiver cannot hold results off. The pipeline is two 34-step restoring dividers
// (one quotient bit per stage) and 20 unrolled CORDIC stages, plus five single stages
// for offsets, mean half-span, scale products, quadrant turn and output. The user must
// write calibration registers through cfg_we/cfg_index/cfg_data only while no sample is
// in flight; the block itself does not enforce this.
module magnetometer_calibrated_heading_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  mch_pkg::sample_t     sample,
	output logic                 done,
	output mch_pkg::result_t     result,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int NDIV = mch_pkg::DIV_BITS;
	localparam int NCOR = mch_pkg::CORDIC_STEPS;
	localparam int LATENCY = 2 + (NDIV + 1) + (NCOR + 1) + 1;

	logic signed [15:0] x_min_q, x_max_q, y_min_q, y_max_q, z_min_q, z_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= -16'sd3195;
			x_max_q <= 16'sd2430;
			y_min_q <= -16'sd6775;
			y_max_q <= 16'sd0;
			z_min_q <= 16'sd0;
			z_max_q <= 16'sd7590;
		end else if (cfg_we) begin
			case (cfg_index)
				mch_pkg::REG_X_MIN: x_min_q <= cfg_data;
				mch_pkg::REG_X_MAX: x_max_q <= cfg_data;
				mch_pkg::REG_Y_MIN: y_min_q <= cfg_data;
				mch_pkg::REG_Y_MAX: y_max_q <= cfg_data;
				mch_pkg::REG_Z_MIN: z_min_q <= cfg_data;
				mch_pkg::REG_Z_MAX: z_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Stage 1: offsets, half-spans and offset-removed samples.
	logic signed [16:0] xo, yo, hx, hy, hz;
	logic signed [17:0] dx, dy, hsum;
	logic [1:0] st1;

	always_comb begin
		xo = mch_pkg::half_tz({x_min_q[15], x_min_q} + {x_max_q[15], x_max_q});
		yo = mch_pkg::half_tz({y_min_q[15], y_min_q} + {y_max_q[15], y_max_q});
		hx = mch_pkg::half_tz({x_max_q[15], x_max_q} - {x_min_q[15], x_min_q});
		hy = mch_pkg::half_tz({y_max_q[15], y_max_q} - {y_min_q[15], y_min_q});
		hz = mch_pkg::half_tz({z_max_q[15], z_max_q} - {z_min_q[15], z_min_q});
		dx = {{2{sample.raw_x[15]}}, sample.raw_x} - {xo[16], xo};
		dy = {{2{sample.raw_y[15]}}, sample.raw_y} - {yo[16], yo};
		hsum = {hx[16], hx} + {hy[16], hy} + {hz[16], hz};
		if (sample.raw_x == 16'sd0 && sample.raw_y == 16'sd0 && sample.raw_z == 16'sd0)
			st1 = mch_pkg::ST_ZERO_SAMPLE;
		else if (hx == 17'sd0 || hy == 17'sd0)
			st1 = mch_pkg::ST_ZERO_SPAN;
		else
			st1 = mch_pkg::ST_OK;
	end

	logic               v_s1;
	logic signed [17:0] dx_s1, dy_s1, hsum_s1;
	logic signed [16:0] hx_s1, hy_s1;
	logic [1:0]         st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= dx;
		dy_s1 <= dy;
		hsum_s1 <= hsum;
		hx_s1 <= hx;
		hy_s1 <= hy;
		st_s1 <= st1;
	end

	// Stage 2: mean half-span, the sum divided by three through a reciprocal.
	// 87382 is 2^18/3 rounded up; it is exact for magnitudes below 2^17.
	logic [17:0] hsum_abs;
	logic [33:0] third_prod;
	logic [15:0] third_mag;
	logic signed [16:0] avg;

	always_comb begin
		hsum_abs = hsum_s1[17] ? 18'(-hsum_s1) : 18'(hsum_s1);
		third_prod = 34'(hsum_abs[16:0]) * 34'd87382;
		third_mag = third_prod[33:18];
		avg = hsum_s1[17] ? -$signed({1'b0, third_mag}) : $signed({1'b0, third_mag});
	end

	logic               v_s2;
	logic signed [17:0] dx_s2, dy_s2;
	logic signed [16:0] hx_s2, hy_s2, avg_s2;
	logic [1:0]         st_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		hx_s2 <= hx_s1;
		hy_s2 <= hy_s1;
		avg_s2 <= avg;
		st_s2 <= st_s1;
	end

	// Stage 3: scale products, split into sign and magnitude for the dividers.
	logic signed [34:0] px, py;
	logic [34:0] px_abs, py_abs;
	logic [16:0] hx_abs, hy_abs;

	always_comb begin
		px = dx_s2 * avg_s2;
		py = dy_s2 * avg_s2;
		px_abs = px[34] ? 35'(-px) : 35'(px);
		py_abs = py[34] ? 35'(-py) : 35'(py);
		hx_abs = hx_s2[16] ? 17'(-hx_s2) : 17'(hx_s2);
		hy_abs = hy_s2[16] ? 17'(-hy_s2) : 17'(hy_s2);
	end

	// Divider pipeline: entry 0 is loaded by stage 3, entry k holds k quotient bits.
	logic              dv_v_s4   [0:NDIV];
	logic [1:0]        dv_st_s4  [0:NDIV];
	logic              dv_sx_s4  [0:NDIV];
	logic              dv_sy_s4  [0:NDIV];
	logic [15:0]       dv_dx_s4  [0:NDIV];
	logic [15:0]       dv_dy_s4  [0:NDIV];
	logic [15:0]       dv_rx_s4  [0:NDIV];
	logic [15:0]       dv_ry_s4  [0:NDIV];
	logic [NDIV-1:0]   dv_nx_s4  [0:NDIV];
	logic [NDIV-1:0]   dv_ny_s4  [0:NDIV];
	logic [NDIV-1:0]   dv_qx_s4  [0:NDIV];
	logic [NDIV-1:0]   dv_qy_s4  [0:NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s4[0] <= 1'b0;
		end else begin
			dv_v_s4[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dv_st_s4[0] <= st_s2;
		dv_sx_s4[0] <= px[34] ^ hx_s2[16];
		dv_sy_s4[0] <= py[34] ^ hy_s2[16];
		dv_dx_s4[0] <= hx_abs[15:0];
		dv_dy_s4[0] <= hy_abs[15:0];
		dv_rx_s4[0] <= '0;
		dv_ry_s4[0] <= '0;
		dv_nx_s4[0] <= px_abs[NDIV-1:0];
		dv_ny_s4[0] <= py_abs[NDIV-1:0];
		dv_qx_s4[0] <= '0;
		dv_qy_s4[0] <= '0;
	end

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [16:0] trial_x, trial_y;
		logic        ge_x, ge_y;

		always_comb begin
			trial_x = {dv_rx_s4[k], dv_nx_s4[k][NDIV-1]};
			trial_y = {dv_ry_s4[k], dv_ny_s4[k][NDIV-1]};
			ge_x = trial_x >= {1'b0, dv_dx_s4[k]};
			ge_y = trial_y >= {1'b0, dv_dy_s4[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s4[k+1] <= 1'b0;
			end else begin
				dv_v_s4[k+1] <= dv_v_s4[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_st_s4[k+1] <= dv_st_s4[k];
			dv_sx_s4[k+1] <= dv_sx_s4[k];
			dv_sy_s4[k+1] <= dv_sy_s4[k];
			dv_dx_s4[k+1] <= dv_dx_s4[k];
			dv_dy_s4[k+1] <= dv_dy_s4[k];
			dv_rx_s4[k+1] <= ge_x ? 16'(trial_x - {1'b0, dv_dx_s4[k]}) : trial_x[15:0];
			dv_ry_s4[k+1] <= ge_y ? 16'(trial_y - {1'b0, dv_dy_s4[k]}) : trial_y[15:0];
			dv_nx_s4[k+1] <= {dv_nx_s4[k][NDIV-2:0], 1'b0};
			dv_ny_s4[k+1] <= {dv_ny_s4[k][NDIV-2:0], 1'b0};
			dv_qx_s4[k+1] <= {dv_qx_s4[k][NDIV-2:0], ge_x};
			dv_qy_s4[k+1] <= {dv_qy_s4[k][NDIV-2:0], ge_y};
		end
	end

	// CORDIC entry: calibrated values scaled by 2^24, then the quadrant turn.
	// The vector is (x, y) = (cy, cx) so the angle is atan2(cx, cy).
	logic signed [63:0] qx_sc, qy_sc, cor_x0, cor_y0;
	logic signed [31:0] cor_z0;

	always_comb begin
		qx_sc = {{(64-NDIV-24){1'b0}}, dv_qx_s4[NDIV], 24'd0};
		qy_sc = {{(64-NDIV-24){1'b0}}, dv_qy_s4[NDIV], 24'd0};
		if (dv_sx_s4[NDIV])
			qx_sc = -qx_sc;
		if (dv_sy_s4[NDIV])
			qy_sc = -qy_sc;
		cor_x0 = qy_sc;
		cor_y0 = qx_sc;
		cor_z0 = 32'sd0;
		if (qy_sc < 0) begin
			if (qx_sc >= 0) begin
				cor_x0 = qx_sc;
				cor_y0 = -qy_sc;
				cor_z0 = 32'sd5898240;
			end else begin
				cor_x0 = -qx_sc;
				cor_y0 = qy_sc;
				cor_z0 = -32'sd5898240;
			end
		end
	end

	logic               cr_v_s5  [0:NCOR];
	logic [1:0]         cr_st_s5 [0:NCOR];
	logic signed [63:0] cr_x_s5  [0:NCOR];
	logic signed [63:0] cr_y_s5  [0:NCOR];
	logic signed [31:0] cr_z_s5  [0:NCOR];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_v_s5[0] <= 1'b0;
		end else begin
			cr_v_s5[0] <= dv_v_s4[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		cr_st_s5[0] <= dv_st_s4[NDIV];
		cr_x_s5[0] <= cor_x0;
		cr_y_s5[0] <= cor_y0;
		cr_z_s5[0] <= cor_z0;
	end

	for (genvar i = 0; i < NCOR; i++) begin : g_cordic
		logic signed [31:0] step_ang;
		assign step_ang = $signed({10'd0, mch_pkg::atan_lut(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_v_s5[i+1] <= 1'b0;
			end else begin
				cr_v_s5[i+1] <= cr_v_s5[i];
			end
		end

		// Once y reaches zero the vector is on the axis and later stages hold it.
		always_ff @(posedge clk) begin
			cr_st_s5[i+1] <= cr_st_s5[i];
			if (cr_y_s5[i] == 64'sd0) begin
				cr_x_s5[i+1] <= cr_x_s5[i];
				cr_y_s5[i+1] <= cr_y_s5[i];
				cr_z_s5[i+1] <= cr_z_s5[i];
			end else if (cr_y_s5[i] > 64'sd0) begin
				cr_x_s5[i+1] <= cr_x_s5[i] + (cr_y_s5[i] >>> i);
				cr_y_s5[i+1] <= cr_y_s5[i] - (cr_x_s5[i] >>> i);
				cr_z_s5[i+1] <= cr_z_s5[i] + step_ang;
			end else begin
				cr_x_s5[i+1] <= cr_x_s5[i] - (cr_y_s5[i] >>> i);
				cr_y_s5[i+1] <= cr_y_s5[i] + (cr_x_s5[i] >>> i);
				cr_z_s5[i+1] <= cr_z_s5[i] - step_ang;
			end
		end
	end

	// Output: whole degrees truncated toward zero, wrapped into 0..359.
	logic signed [31:0] z_fin, z_abs;
	logic signed [15:0] deg;
	logic [8:0]         heading;

	always_comb begin
		z_fin = cr_z_s5[NCOR];
		z_abs = z_fin[31] ? -z_fin : z_fin;
		deg = $signed({1'b0, z_abs[30:16]});
		if (z_fin[31])
			deg = -deg;
		if (deg < 0)
			deg = deg + 16'sd360;
		if (deg >= 16'sd360)
			deg = deg - 16'sd360;
		if (deg < 0)
			deg = 16'sd0;
		heading = (cr_st_s5[NCOR] == mch_pkg::ST_OK) ? deg[8:0] : 9'd0;
	end

	logic done_q;
	mch_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cr_v_s5[NCOR];
		end
	end

	always_ff @(posedge clk) begin
		result_q.heading_deg <= heading;
		result_q.status <= cr_st_s5[NCOR];
	end

	assign done = done_q;
	assign result = result_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a request at the pipeline latency");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.heading_deg < 9'd360))
		else $error("heading outside 0..359");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != mch_pkg::ST_OK) |-> (result.heading_deg == 9'd0))
		else $error("flagged result carries a heading");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == mch_pkg::ST_OK || result.status == mch_pkg::ST_ZERO_SAMPLE
			|| result.status == mch_pkg::ST_ZERO_SPAN))
		else $error("undefined status code");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int LATENCY = 59;
	localparam int N_RANDOM = 630;
	localparam longint CYCLE_LIMIT = 400000;

	// Angle increments of the vectoring rotation, in 2^-16 degree.
	localparam longint ARCTAN_STEP [0:22] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
	};

	class heading_scoreboard;
		mch_pkg::result_t pending_headings[$];
		int mismatches;
		int signed cal[6];

		function void reset_cal();
			cal[mch_pkg::REG_X_MIN] = -3195;
			cal[mch_pkg::REG_X_MAX] = 2430;
			cal[mch_pkg::REG_Y_MIN] = -6775;
			cal[mch_pkg::REG_Y_MAX] = 0;
			cal[mch_pkg::REG_Z_MIN] = 0;
			cal[mch_pkg::REG_Z_MAX] = 7590;
			mismatches = 0;
		endfunction

		function void write_cal(logic [2:0] idx, logic signed [15:0] val);
			if (idx <= mch_pkg::REG_Z_MAX) begin
				cal[idx] = val;
			end
		endfunction

		function longint vector_angle(longint yv, longint xv);
			longint x, y, z, t, dx, dy;
			x = xv;
			y = yv;
			z = 0;
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; z = 90 * 65536;
				end else begin
					x = -y; y = t; z = -90 * 65536;
				end
			end
			for (int i = 0; i < mch_pkg::CORDIC_STEPS; i++) begin
				if (y == 0) break;
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx; y -= dy; z += (i < 23) ? ARCTAN_STEP[i] : 0;
				end else begin
					x -= dx; y += dy; z -= (i < 23) ? ARCTAN_STEP[i] : 0;
				end
			end
			return z;
		endfunction

		function void note_sample(mch_pkg::sample_t s);
			mch_pkg::result_t r;
			int signed xo, yo, hx, hy, hz, avg;
			longint cx, cy, deg;
			r = '0;
			if (s.raw_x == 0 && s.raw_y == 0 && s.raw_z == 0) begin
				r.status = mch_pkg::ST_ZERO_SAMPLE;
			end else begin
				xo = (cal[mch_pkg::REG_X_MIN] + cal[mch_pkg::REG_X_MAX]) / 2;
				yo = (cal[mch_pkg::REG_Y_MIN] + cal[mch_pkg::REG_Y_MAX]) / 2;
				hx = (cal[mch_pkg::REG_X_MAX] - cal[mch_pkg::REG_X_MIN]) / 2;
				hy = (cal[mch_pkg::REG_Y_MAX] - cal[mch_pkg::REG_Y_MIN]) / 2;
				hz = (cal[mch_pkg::REG_Z_MAX] - cal[mch_pkg::REG_Z_MIN]) / 2;
				if (hx == 0 || hy == 0) begin
					r.status = mch_pkg::ST_ZERO_SPAN;
				end else begin
					avg = (hx + hy + hz) / 3;
					cx = (longint'(int'(s.raw_x) - xo) * avg) / hx;
					cy = (longint'(int'(s.raw_y) - yo) * avg) / hy;
					deg = vector_angle(cx * (64'sd1 <<< 24), cy * (64'sd1 <<< 24)) / 65536;
					if (deg < 0) deg += 360;
					if (deg >= 360) deg -= 360;
					if (deg < 0) deg = 0;
					r.heading_deg = deg[8:0];
					r.status = mch_pkg::ST_OK;
				end
			end
			pending_headings = {pending_headings, r};
		endfunction

		function void check_result(mch_pkg::result_t got);
			mch_pkg::result_t exp_r;
			if (pending_headings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result heading=%0d status=%0d",
						got.heading_deg, got.status);
				return;
			end
			exp_r = pending_headings.pop_front();
			if (got.heading_deg !== exp_r.heading_deg || got.status !== exp_r.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected heading=%0d status=%0d, got heading=%0d status=%0d",
						exp_r.heading_deg, exp_r.status, got.heading_deg, got.status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mch_pkg::sample_t sample = '0;
	logic done;
	mch_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	heading_scoreboard board;
	longint cycles = 0;
	int idle_pct = 0;

	magnetometer_calibrated_heading_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) board.check_result(result);
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		board.write_cal(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Leaves start high on return; the caller lowers it when the burst ends.
	task automatic send_sample(mch_pkg::sample_t s);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_sample(s);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending_headings.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic mch_pkg::sample_t rand_sample();
		mch_pkg::sample_t s;
		case ($urandom_range(9))
			0: s = '{16'sh8000, 16'sh7fff, 16'($urandom)};
			1: s = '{$urandom_range(1) ? 16'sh7fff : 16'sh8000, 16'($urandom), 16'sd0};
			2: s = '{16'(int'($urandom_range(40)) - 20), 16'(int'($urandom_range(40)) - 20),
				16'(int'($urandom_range(2)) - 1)};
			default: s = '{16'($urandom), 16'($urandom), 16'($urandom)};
		endcase
		return s;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if (i < n / 3) idle_pct = 36;
			else if (i < 2 * n / 3) idle_pct = 73;
			else idle_pct = 0;
			send_sample(rand_sample());
		end
		drain();
	endtask

	task automatic load_cal(int xa, int xb, int ya, int yb, int za, int zb);
		write_reg(mch_pkg::REG_X_MIN, 16'(xa));
		write_reg(mch_pkg::REG_X_MAX, 16'(xb));
		write_reg(mch_pkg::REG_Y_MIN, 16'(ya));
		write_reg(mch_pkg::REG_Y_MAX, 16'(yb));
		write_reg(mch_pkg::REG_Z_MIN, 16'(za));
		write_reg(mch_pkg::REG_Z_MAX, 16'(zb));
	endtask

	initial begin
		board = new();
		board.reset_cal();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed samples under the reset calibration.
		send_sample('{16'sd0, 16'sd0, 16'sd0});
		send_sample('{16'sd0, 16'sd0, 16'sd1});
		send_sample('{16'sh7fff, 16'sh7fff, 16'sh7fff});
		send_sample('{16'sh8000, 16'sh8000, 16'sh8000});
		send_sample('{16'sh8000, 16'sh7fff, 16'sd0});
		send_sample('{16'sh7fff, 16'sh8000, 16'sd0});
		// Calibrated vector exactly zero: raw equals the offsets.
		send_sample('{-16'sd382, -16'sd3387, 16'sd5});
		send_sample('{16'sd1000, -16'sd3387, 16'sd0});
		send_sample('{-16'sd1000, -16'sd3387, 16'sd0});
		send_sample('{-16'sd382, 16'sd1000, 16'sd0});
		send_sample('{-16'sd382, -16'sd9000, 16'sd0});
		send_sample('{-16'sd2000, -16'sd9000, 16'sd0});
		drain();

		// Zero x span, then zero y span, then inverted spans on all three axes.
		load_cal(100, 101, -50, 50, 0, 0);
		send_sample('{16'sd5, 16'sd5, 16'sd0});
		send_sample('{16'sd0, 16'sd0, 16'sd0});
		drain();
		load_cal(-100, 100, 7, 8, 0, 0);
		send_sample('{16'sd5, 16'sd5, 16'sd0});
		drain();
		load_cal(500, -500, 300, -300, 20, 10);
		send_sample('{16'sd50, 16'sd70, 16'sd0});
		send_sample('{-16'sd50, 16'sd70, 16'sd0});
		drain();
		// Writes beyond the last register must leave the calibration unchanged.
		write_reg(3'd6, 16'hffff);
		write_reg(3'd7, 16'h1234);
		send_sample('{16'sd3, -16'sd9, 16'sd0});
		drain();

		load_cal(-32768, 32767, -32768, 32767, -32768, 32767);
		random_phase(160);
		load_cal(32767, -32768, 32767, -32768, 32767, -32768);
		random_phase(100);
		load_cal(-3195, 2430, -6775, 0, 0, 7590);
		random_phase(170);
		for (int k = 0; k < 4; k++) begin
			load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			random_phase(50);
		end

		if (board.mismatches == 0 && board.pending_headings.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
